/* hw/rtl/bta_pkg.sv */
`default_nettype none

package bta_pkg;

   localparam int THREADS_DEFAULT     = 8;
   localparam int TICKET_BITS_DEFAULT = 16;

   localparam int THREAD_W     = 3;
   localparam int COUNT_W      = 4;
   localparam int STATUS_W     = 3;
   localparam int TICKET_OUT_W = 16;
   localparam int CSR_DATA_W   = 32;
   localparam int CSR_ADDR_W   = 3;

   localparam logic [COUNT_W-1:0] THREADS_IN_USE_RESET = 4'd8;

   localparam int REG_THREADS_IN_USE = 0;

   localparam logic KIND_REQUEST = 1'b0;
   localparam logic KIND_RELEASE = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK              = 3'd0,
      STATUS_ALREADY_WAITING = 3'd1,
      STATUS_NOT_WAITING     = 3'd2,
      STATUS_OVERFLOW        = 3'd3,
      STATUS_BAD_THREAD      = 3'd4
   } status_type;

endpackage

`default_nettype wire

/* hw/rtl/bakery_ticket_arbiter.sv */
// An accepted request passes the start register, the chain of ticket cells, the result
// register and the response register before rsp_tvalid; the scan token walks the chain
// of ticket cells, one cell per cycle, and the result waits while rsp_tready holds it.
// One transaction is in flight at a time; a new one is taken once the result is loaded.
// Reset (synchronous, active high) clears all tickets, sets threads_in_use to 8
// and empties the response register.
`default_nettype none

module bakery_ticket_arbiter #(
   parameter int THREADS     = bta_pkg::THREADS_DEFAULT,
   parameter int TICKET_BITS = bta_pkg::TICKET_BITS_DEFAULT
) (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 req_tvalid,
   output logic                                req_tready,
   input  wire  [7:0]                          req_tdata,   // [2:0] thread
   input  wire  [0:0]                          req_tuser,   // [0] kind
   output logic                                rsp_tvalid,
   input  wire                                 rsp_tready,
   output logic [23:0]                         rsp_tdata,   // [15:0] ticket, [16] owner_valid,
                                                            // [19:17] owner
   output logic [bta_pkg::STATUS_W-1:0]        rsp_tuser,   // [2:0] status
   input  wire                                 csr_psel,
   input  wire                                 csr_penable,
   input  wire                                 csr_pwrite,
   input  wire  [bta_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  wire  [bta_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [bta_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                csr_pready
);

   localparam int IDX_BITS = $clog2(THREADS);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_SCAN = 3'b010,
      ST_HOLD = 3'b100
   } state_type;

   state_type state_ff, state_in;

   logic [bta_pkg::COUNT_W-1:0]  threads_ff, threads_in;
   logic                         kind_ff, kind_in;
   logic [bta_pkg::THREAD_W-1:0] thr_ff, thr_in;
   logic                         start_ff, start_in;

   bta_pkg::status_type              res_status_ff, res_status_in;
   logic [bta_pkg::TICKET_OUT_W-1:0] res_ticket_ff, res_ticket_in;
   logic                             res_valid_ff, res_valid_in;
   logic [bta_pkg::THREAD_W-1:0]     res_owner_ff, res_owner_in;

   logic                             rsp_valid_ff, rsp_valid_in;
   bta_pkg::status_type              rsp_status_ff, rsp_status_in;
   logic [bta_pkg::TICKET_OUT_W-1:0] rsp_ticket_ff, rsp_ticket_in;
   logic                             rsp_ovalid_ff, rsp_ovalid_in;
   logic [bta_pkg::THREAD_W-1:0]     rsp_owner_ff, rsp_owner_in;

   logic                   link_go    [THREADS+1];
   logic [TICKET_BITS-1:0] link_max   [THREADS+1];
   logic [TICKET_BITS-1:0] link_best  [THREADS+1];
   logic [IDX_BITS-1:0]    link_idx   [THREADS+1];
   logic                   link_found [THREADS+1];
   logic [TICKET_BITS-1:0] link_mine  [THREADS+1];

   logic                   req_accept;
   logic                   csr_write;
   logic                   scan_end;
   logic                   bad_thread;
   logic [TICKET_BITS-1:0] given;
   bta_pkg::status_type    status;
   logic                   wr_en;
   logic [TICKET_BITS-1:0] wr_value;
   logic                   rsp_load;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready
                       && (csr_paddr[2] == 1'(bta_pkg::REG_THREADS_IN_USE));

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[2] == 1'(bta_pkg::REG_THREADS_IN_USE)) begin
         csr_prdata = bta_pkg::CSR_DATA_W'(threads_ff);
      end
   end

   assign link_go[0]    = start_ff;
   assign link_max[0]   = '0;
   assign link_best[0]  = '0;
   assign link_idx[0]   = '0;
   assign link_found[0] = 1'b0;
   assign link_mine[0]  = '0;

   for (genvar i = 0; i < THREADS; i++) begin : g_cell
      bta_cell #(
         .TICKET_BITS (TICKET_BITS),
         .IDX_BITS    (IDX_BITS),
         .INDEX       (i)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .count_i    (threads_ff),
         .kind_i     (kind_ff),
         .thr_i      (thr_ff),
         .wr_en      (wr_en),
         .wr_value   (wr_value),
         .from_go    (link_go[i]),
         .from_max   (link_max[i]),
         .from_best  (link_best[i]),
         .from_idx   (link_idx[i]),
         .from_found (link_found[i]),
         .from_mine  (link_mine[i]),
         .to_go      (link_go[i+1]),
         .to_max     (link_max[i+1]),
         .to_best    (link_best[i+1]),
         .to_idx     (link_idx[i+1]),
         .to_found   (link_found[i+1]),
         .to_mine    (link_mine[i+1])
      );
   end

   always_comb begin
      scan_end   = (state_ff == ST_SCAN) && link_go[THREADS];
      bad_thread = (int'(thr_ff) >= int'(threads_ff)) || (int'(thr_ff) >= THREADS);
      given      = link_max[THREADS] + TICKET_BITS'(1);

      if (bad_thread) begin
         status = bta_pkg::STATUS_BAD_THREAD;
      end else if (kind_ff == bta_pkg::KIND_REQUEST) begin
         if (link_mine[THREADS] != '0) begin
            status = bta_pkg::STATUS_ALREADY_WAITING;
         end else if (&link_max[THREADS]) begin
            status = bta_pkg::STATUS_OVERFLOW;
         end else begin
            status = bta_pkg::STATUS_OK;
         end
      end else if (link_mine[THREADS] == '0) begin
         status = bta_pkg::STATUS_NOT_WAITING;
      end else begin
         status = bta_pkg::STATUS_OK;
      end

      wr_en    = scan_end && (status == bta_pkg::STATUS_OK);
      wr_value = (kind_ff == bta_pkg::KIND_RELEASE) ? '0 : given;

      res_status_in = res_status_ff;
      res_ticket_in = res_ticket_ff;
      res_valid_in  = res_valid_ff;
      res_owner_in  = res_owner_ff;
      if (scan_end) begin
         res_status_in = status;
         res_ticket_in = '0;
         res_valid_in  = link_found[THREADS];
         res_owner_in  = link_found[THREADS] ? bta_pkg::THREAD_W'(link_idx[THREADS]) : '0;
         if (status == bta_pkg::STATUS_OK && kind_ff == bta_pkg::KIND_REQUEST) begin
            res_ticket_in = bta_pkg::TICKET_OUT_W'(given);
            if (!link_found[THREADS]) begin
               res_valid_in = 1'b1;
               res_owner_in = thr_ff;
            end
         end
      end
   end

   always_comb begin
      state_in   = state_ff;
      start_in   = req_accept;
      kind_in    = req_accept ? req_tuser[0] : kind_ff;
      thr_in     = req_accept ? req_tdata[bta_pkg::THREAD_W-1:0] : thr_ff;
      threads_in = csr_write ? csr_pwdata[bta_pkg::COUNT_W-1:0] : threads_ff;
      rsp_load   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (scan_end) begin
               state_in = ST_HOLD;
            end
         end
         ST_HOLD: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_valid_in  = rsp_load || (rsp_valid_ff && !rsp_tready);
      rsp_status_in = rsp_load ? res_status_ff : rsp_status_ff;
      rsp_ticket_in = rsp_load ? res_ticket_ff : rsp_ticket_ff;
      rsp_ovalid_in = rsp_load ? res_valid_ff : rsp_ovalid_ff;
      rsp_owner_in  = rsp_load ? res_owner_ff : rsp_owner_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         start_ff     <= 1'b0;
         threads_ff   <= bta_pkg::THREADS_IN_USE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         start_ff     <= start_in;
         threads_ff   <= threads_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff       <= kind_in;
      thr_ff        <= thr_in;
      res_status_ff <= res_status_in;
      res_ticket_ff <= res_ticket_in;
      res_valid_ff  <= res_valid_in;
      res_owner_ff  <= res_owner_in;
      rsp_status_ff <= rsp_status_in;
      rsp_ticket_ff <= rsp_ticket_in;
      rsp_ovalid_ff <= rsp_ovalid_in;
      rsp_owner_ff  <= rsp_owner_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {4'd0, rsp_owner_ff, rsp_ovalid_ff, rsp_ticket_ff};

`ifndef ASSERT_OFF
   a_token_only_in_scan: assert property (@(posedge clock) disable iff (reset)
      link_go[THREADS] |-> state_ff == ST_SCAN)
      else $error("scan token left the chain outside a scan");

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> !req_tready && start_ff)
      else $error("second transaction taken while one is in flight");

   a_ticket_only_on_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_status_ff != bta_pkg::STATUS_OK |-> rsp_ticket_ff == '0)
      else $error("ticket reported on a failed event");

   a_owner_zero_when_none: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_ovalid_ff |-> rsp_owner_ff == '0)
      else $error("owner reported without a waiting thread");

   a_write_only_at_scan_end: assert property (@(posedge clock) disable iff (reset)
      wr_en |=> state_ff == ST_HOLD)
      else $error("ticket write outside scan end");
`endif

endmodule

`default_nettype wire

/* hw/rtl/bta_cell.sv */
`default_nettype none

module bta_cell #(
   parameter int TICKET_BITS = bta_pkg::TICKET_BITS_DEFAULT,
   parameter int IDX_BITS    = 3,
   parameter int INDEX       = 0
) (
   input  wire                             clock,
   input  wire                             reset,
   input  wire  [bta_pkg::COUNT_W-1:0]     count_i,
   input  wire                             kind_i,
   input  wire  [bta_pkg::THREAD_W-1:0]    thr_i,
   input  wire                             wr_en,
   input  wire  [TICKET_BITS-1:0]          wr_value,
   input  wire                             from_go,
   input  wire  [TICKET_BITS-1:0]          from_max,
   input  wire  [TICKET_BITS-1:0]          from_best,
   input  wire  [IDX_BITS-1:0]             from_idx,
   input  wire                             from_found,
   input  wire  [TICKET_BITS-1:0]          from_mine,
   output logic                            to_go,
   output logic [TICKET_BITS-1:0]          to_max,
   output logic [TICKET_BITS-1:0]          to_best,
   output logic [IDX_BITS-1:0]             to_idx,
   output logic                            to_found,
   output logic [TICKET_BITS-1:0]          to_mine
);

   logic [TICKET_BITS-1:0] tkt_ff, tkt_in;
   logic                   go_ff, go_in;
   logic [TICKET_BITS-1:0] max_ff, max_in;
   logic [TICKET_BITS-1:0] best_ff, best_in;
   logic [IDX_BITS-1:0]    idx_ff, idx_in;
   logic                   found_ff, found_in;
   logic [TICKET_BITS-1:0] mine_ff, mine_in;
   logic                   active;
   logic                   is_thr;
   logic [TICKET_BITS-1:0] bid;
   logic                   take;

   always_comb begin
      active = INDEX < int'(count_i);
      is_thr = INDEX == int'(thr_i);
      bid    = (kind_i == bta_pkg::KIND_RELEASE && is_thr) ? '0 : tkt_ff;
      take   = active && (bid != '0) && (!from_found || bid < from_best);

      go_in    = from_go;
      max_in   = (active && tkt_ff > from_max) ? tkt_ff : from_max;
      best_in  = take ? bid : from_best;
      idx_in   = take ? IDX_BITS'(INDEX) : from_idx;
      found_in = from_found || take;
      mine_in  = is_thr ? tkt_ff : from_mine;
      tkt_in   = (wr_en && is_thr) ? wr_value : tkt_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         go_ff  <= 1'b0;
         tkt_ff <= '0;
      end else begin
         go_ff  <= go_in;
         tkt_ff <= tkt_in;
      end
   end

   always_ff @(posedge clock) begin
      max_ff   <= max_in;
      best_ff  <= best_in;
      idx_ff   <= idx_in;
      found_ff <= found_in;
      mine_ff  <= mine_in;
   end

   assign to_go    = go_ff;
   assign to_max   = max_ff;
   assign to_best  = best_ff;
   assign to_idx   = idx_ff;
   assign to_found = found_ff;
   assign to_mine  = mine_ff;

endmodule

`default_nettype wire
